// ----- rtl/core/bbts_pkg.sv -----
package bbts_pkg;

    // Fixed field widths of the channels and the register port
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int COORD_W   = 32;
    localparam int PIX_W     = 8;
    localparam int SAMPLE_W  = 17;
    localparam int OUT_FRAC  = 16;

    // Item commands
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic                      cmd;
        logic signed [COORD_W-1:0] tex_u;
        logic signed [COORD_W-1:0] tex_v;
        logic [PIX_W-1:0]          pixel_x;
        logic [PIX_W-1:0]          pixel_y;
        logic                      pixel_bit;
    } t_in_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_value;
        logic                write_ignored;
    } t_out_item;

    // Control that travels with an item down the back end
    typedef struct packed {
        logic cmd;
        logic ign;
    } t_tag;

    // Stage loads of the blend pipeline
    typedef struct packed {
        logic row;
        logic mul;
        logic sum;
    } t_blend_en;

endpackage

// ----- rtl/core/bilinear_bitmap_tiled_sampler.sv -----
// Tiled bilinear sampler over a one-bit-per-pixel bitmap.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries write and
// sample items; output channel (o_out_valid / i_out_ready / o_out_data)
// returns one result per item, in order. Each transfer happens when valid
// and ready are both high at a rising edge.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 image width, 1 image height) at once; write only while idle.
// Path: a result is registered in turn by the scale, bitmap, row blend,
// column multiply and output stages. Throughput: one item per cycle
// while i_out_ready stays high, set by the five-stage pipeline in which
// the bitmap stage writes one pixel or reads four from two copies of the
// bitmap memory. A write followed at once by a sample of it is seen.
// Reset: clears all stage valid bits and sets both sizes to 256. The bitmap
// memory is not cleared; its pixels are undefined until written.
// Stall: with i_out_ready low the output holds; earlier stages keep filling
// their empty slots, and o_in_ready drops once every stage is occupied.
module bilinear_bitmap_tiled_sampler
    import bbts_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(256);

    logic [CFG_W-1:0]     r_img_w, r_img_h;
    logic [5:1]           en, r_vld, n_vld;
    logic [FRAC_BITS-1:0] fu, fv, xf, yf;
    logic [FRAC_BITS-1:0] r2_xf, r2_yf;
    logic [XW-1:0]        x0, x1;
    logic [YW-1:0]        y0, y1;
    logic [CFG_W-1:0]     size_w, size_h;
    logic                 r1_cmd, r1_bit;
    logic [PIX_W-1:0]     r1_x, r1_y;
    logic                 ign, mem_wr, mem_rd;
    logic [3:0]           bits;
    t_tag                 r2_tag;
    t_blend_en            blend_en;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= SIZE_RESET;
            r_img_h <= SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_img_w <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_img_h <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // Advance a stage when it is empty or its successor advances
    always_comb begin
        en[5] = !r_vld[5] || i_out_ready;
        for (int k = 4; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        n_vld[1] = en[1] ? i_in_valid : r_vld[1];
        for (int k = 2; k <= 5; k++) begin
            n_vld[k] = en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready = en[1];

    // Stage one: take the fractions of u and of -v and scale them
    assign fu = i_in_data.tex_u[FRAC_BITS-1:0];
    assign fv = FRAC_BITS'(0) - i_in_data.tex_v[FRAC_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_cmd <= i_in_data.cmd;
            r1_x   <= i_in_data.pixel_x;
            r1_y   <= i_in_data.pixel_y;
            r1_bit <= i_in_data.pixel_bit;
        end
    end

    bbts_axis #(
        .MAX_SIZE  (MAX_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_axis_x (
        .i_clk      (i_clk),
        .i_en       (en[1]),
        .i_frac     (fu),
        .i_size_raw (r_img_w),
        .o_p0       (x0),
        .o_p1       (x1),
        .o_fr       (xf),
        .o_size     (size_w)
    );

    bbts_axis #(
        .MAX_SIZE  (MAX_HEIGHT),
        .FRAC_BITS (FRAC_BITS)
    ) u_axis_y (
        .i_clk      (i_clk),
        .i_en       (en[1]),
        .i_frac     (fv),
        .i_size_raw (r_img_h),
        .o_p0       (y0),
        .o_p1       (y1),
        .o_fr       (yf),
        .o_size     (size_h)
    );

    // Stage two: drop writes outside the size, access the bitmap
    assign ign    = ({1'b0, r1_x} >= size_w) || ({1'b0, r1_y} >= size_h);
    assign mem_wr = en[2] && r_vld[1] && (r1_cmd == CMD_WRITE) && !ign;
    assign mem_rd = en[2] && r_vld[1] && (r1_cmd == CMD_SAMPLE);

    bbts_bitmap #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_bitmap (
        .i_clk    (i_clk),
        .i_wr     (mem_wr),
        .i_wr_bit (r1_bit),
        .i_wr_x   (XW'(r1_x)),
        .i_wr_y   (YW'(r1_y)),
        .i_rd     (mem_rd),
        .i_x0     (x0),
        .i_x1     (x1),
        .i_y0     (y0),
        .i_y1     (y1),
        .o_bits   (bits)
    );

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_tag.cmd <= r1_cmd;
            r2_tag.ign <= ign;
            r2_xf      <= xf;
            r2_yf      <= yf;
        end
    end

    // Stages three to five: weight the four bits
    assign blend_en.row = en[3];
    assign blend_en.mul = en[4];
    assign blend_en.sum = en[5];

    bbts_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .i_clk  (i_clk),
        .i_en   (blend_en),
        .i_tag  (r2_tag),
        .i_bits (bits),
        .i_xf   (r2_xf),
        .i_yf   (r2_yf),
        .o_data (o_out_data)
    );

    assign o_out_valid = r_vld[5];

    // Coverage never exceeds one
    a_sample_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.sample_value <= SAMPLE_W'(65536)))
        else $error("sample value above 1.0");

    // A flagged write carries no coverage
    a_ignored_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.write_ignored) |->
        (o_out_data.sample_value == '0))
        else $error("ignored write with nonzero sample value");

    // An input transfer lands in stage one
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[1])
        else $error("accepted item lost at pipeline entry");

    // A stalled output stage keeps its item
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[5] && !i_out_ready) |=> (r_vld[5] && $stable(o_out_data)))
        else $error("stalled result changed");

endmodule

// ----- rtl/core/bbts_axis.sv -----
module bbts_axis
    import bbts_pkg::*;
#(
    parameter int MAX_SIZE  = 256,
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [FRAC_BITS-1:0]        i_frac,
    input  logic [CFG_W-1:0]            i_size_raw,
    output logic [$clog2(MAX_SIZE)-1:0] o_p0,
    output logic [$clog2(MAX_SIZE)-1:0] o_p1,
    output logic [FRAC_BITS-1:0]        o_fr,
    output logic [CFG_W-1:0]            o_size
);

    localparam int IW       = $clog2(MAX_SIZE);
    localparam int SW       = FRAC_BITS + CFG_W;
    localparam int SIZE_LIM = (1 << CFG_W) - 1;
    localparam logic [CFG_W-1:0] SIZE_CAP =
        (MAX_SIZE > SIZE_LIM) ? CFG_W'(SIZE_LIM) : CFG_W'(MAX_SIZE);

    logic [CFG_W-1:0] eff;
    logic [SW-1:0]    r_s;
    logic [CFG_W-1:0] r_size;
    logic [CFG_W-1:0] p0_w;
    logic [CFG_W:0]   p0_inc;

    // Clamp the size register to the usable range
    always_comb begin
        if (i_size_raw == '0) begin
            eff = CFG_W'(1);
        end else if (i_size_raw > SIZE_CAP) begin
            eff = SIZE_CAP;
        end else begin
            eff = i_size_raw;
        end
    end

    // Scale the fraction by the size
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s    <= SW'(i_frac) * SW'(eff);
            r_size <= eff;
        end
    end

    // Split into pixel, wrapped neighbour and in-pixel fraction
    assign p0_w   = r_s[SW-1:FRAC_BITS];
    assign p0_inc = {1'b0, p0_w} + (CFG_W+1)'(1);
    assign o_p0   = IW'(p0_w);
    assign o_p1   = (p0_inc < {1'b0, r_size}) ? IW'(p0_inc) : '0;
    assign o_fr   = r_s[FRAC_BITS-1:0];
    assign o_size = r_size;

endmodule

// ----- rtl/core/bbts_bitmap.sv -----
module bbts_bitmap
    import bbts_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                          i_clk,
    input  logic                          i_wr,
    input  logic                          i_wr_bit,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_wr_x,
    input  logic [$clog2(MAX_HEIGHT)-1:0] i_wr_y,
    input  logic                          i_rd,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_x0,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_x1,
    input  logic [$clog2(MAX_HEIGHT)-1:0] i_y0,
    input  logic [$clog2(MAX_HEIGHT)-1:0] i_y1,
    output logic [3:0]                    o_bits
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    // Two copies, each with one write and two reads: top row, bottom row
    logic mem_top [DEPTH];
    logic mem_bot [DEPTH];

    logic [AW-1:0] wa, a00, a10, a01, a11;
    logic [1:0]    r_top, r_bot;

    function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] x,
                                              input logic [YW-1:0] y);
        addr_of = AW'(y) * AW'(MAX_WIDTH) + AW'(x);
    endfunction

    assign wa  = addr_of(i_wr_x, i_wr_y);
    assign a00 = addr_of(i_x0, i_y0);
    assign a10 = addr_of(i_x1, i_y0);
    assign a01 = addr_of(i_x0, i_y1);
    assign a11 = addr_of(i_x1, i_y1);

    // Store the bit and fetch the top pair
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            mem_top[wa] <= i_wr_bit;
        end
        if (i_rd) begin
            r_top[0] <= mem_top[a00];
            r_top[1] <= mem_top[a10];
        end
    end

    // Store the bit and fetch the bottom pair
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            mem_bot[wa] <= i_wr_bit;
        end
        if (i_rd) begin
            r_bot[0] <= mem_bot[a01];
            r_bot[1] <= mem_bot[a11];
        end
    end

    assign o_bits = {r_bot, r_top};

endmodule

// ----- rtl/core/bbts_blend.sv -----
module bbts_blend
    import bbts_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  t_blend_en            i_en,
    input  t_tag                 i_tag,
    input  logic [3:0]           i_bits,
    input  logic [FRAC_BITS-1:0] i_xf,
    input  logic [FRAC_BITS-1:0] i_yf,
    output t_out_item            o_data
);

    localparam int WW    = FRAC_BITS + 1;
    localparam int PW    = 2 * WW;
    localparam int SHIFT = 2 * FRAC_BITS - OUT_FRAC;
    localparam logic [WW-1:0] FRAC_ONE = WW'(1) << FRAC_BITS;

    logic [WW-1:0] ux, uy, row0, row1;
    logic [WW-1:0] r_row0, r_row1, r_uy, r_yf;
    logic [PW-1:0] r_m0, r_m1, sum;
    t_tag          r_tag3, r_tag4;
    t_out_item     r_out;

    // Blend each row horizontally: bits only select the weights
    assign ux   = FRAC_ONE - WW'(i_xf);
    assign uy   = FRAC_ONE - WW'(i_yf);
    assign row0 = (i_bits[0] ? ux : '0) + (i_bits[1] ? WW'(i_xf) : '0);
    assign row1 = (i_bits[2] ? ux : '0) + (i_bits[3] ? WW'(i_xf) : '0);

    always_ff @(posedge i_clk) begin
        if (i_en.row) begin
            r_row0 <= row0;
            r_row1 <= row1;
            r_uy   <= uy;
            r_yf   <= WW'(i_yf);
            r_tag3 <= i_tag;
        end
    end

    // Weight the rows vertically
    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            r_m0   <= PW'(r_row0) * PW'(r_uy);
            r_m1   <= PW'(r_row1) * PW'(r_yf);
            r_tag4 <= r_tag3;
        end
    end

    // Add, truncate to Q1.16 and form the result
    assign sum = r_m0 + r_m1;

    always_ff @(posedge i_clk) begin
        if (i_en.sum) begin
            r_out.sample_value  <= (r_tag4.cmd == CMD_SAMPLE) ?
                                   SAMPLE_W'(sum >> SHIFT) : '0;
            r_out.write_ignored <= (r_tag4.cmd == CMD_WRITE) && r_tag4.ign;
        end
    end

    assign o_data = r_out;

endmodule
